// File: design/lfu_cache_controller_macros.svh
// Assertion macros used by the checker file of the LFU cache controller.
`ifndef LFU_CACHE_CONTROLLER_MACROS_SVH
`define LFU_CACHE_CONTROLLER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define LFU_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("LFU cache check failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define LFU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("LFU cache check failed");

`endif

// File: design/lfu_pkg.sv
// Shared constants and types of the LFU cache controller.
`timescale 1ns / 1ps
`default_nettype none

package lfu_pkg;

  // Default number of entries in the store.
  localparam int unsigned EntriesDef = 16;

  // Field widths.
  localparam int unsigned KeyW   = 32;
  localparam int unsigned ValW   = 32;
  localparam int unsigned CountW = 16;
  localparam int unsigned CapW   = 5;

  // Saturation point of the use count.
  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

  // Use count of a freshly inserted entry.
  localparam logic [CountW-1:0] CountInit = CountW'(1);

  // Capacity register value after reset.
  localparam logic [CapW-1:0] CapacityRst = CapW'(16);

  // Request opcodes.
  localparam logic OpGet = 1'b0;
  localparam logic OpPut = 1'b1;

  // Write enables of the four entry memories.
  typedef struct packed {
    logic key;
    logic val;
    logic cnt;
    logic rank;
  } lfu_wr_en_t;

  // Outcome of one scan over the store.
  typedef struct packed {
    logic found;
    logic free;
    logic victim;
  } lfu_scan_flags_t;

endpackage

`default_nettype wire

// File: design/lfu_store.sv
// Entry memories of the LFU cache: key, value, use count and recency rank.
`timescale 1ns / 1ps
`default_nettype none

module lfu_store import lfu_pkg::*; #(
  parameter int unsigned ENTRIES = EntriesDef,
  parameter int unsigned IdxW    = 4
) (
  input  wire logic              clk_i,
  input  wire logic [IdxW-1:0]   rd_addr_i,
  output logic      [KeyW-1:0]   rd_key_o,
  output logic      [ValW-1:0]   rd_val_o,
  output logic      [CountW-1:0] rd_cnt_o,
  output logic      [IdxW-1:0]   rd_rank_o,
  input  wire logic [IdxW-1:0]   wr_addr_i,
  input  wire lfu_wr_en_t        wr_en_i,
  input  wire logic [KeyW-1:0]   wr_key_i,
  input  wire logic [ValW-1:0]   wr_val_i,
  input  wire logic [CountW-1:0] wr_cnt_i,
  input  wire logic [IdxW-1:0]   wr_rank_i
);

  logic [KeyW-1:0]   key_mem_q  [ENTRIES];
  logic [ValW-1:0]   val_mem_q  [ENTRIES];
  logic [CountW-1:0] cnt_mem_q  [ENTRIES];
  logic [IdxW-1:0]   rank_mem_q [ENTRIES];

  logic [KeyW-1:0]   rd_key_q;
  logic [ValW-1:0]   rd_val_q;
  logic [CountW-1:0] rd_cnt_q;
  logic [IdxW-1:0]   rd_rank_q;

  // One write port per memory, all sharing one address.
  always_ff @(posedge clk_i) begin
    if (wr_en_i.key) begin
      key_mem_q[wr_addr_i] <= wr_key_i;
    end
    if (wr_en_i.val) begin
      val_mem_q[wr_addr_i] <= wr_val_i;
    end
    if (wr_en_i.cnt) begin
      cnt_mem_q[wr_addr_i] <= wr_cnt_i;
    end
    if (wr_en_i.rank) begin
      rank_mem_q[wr_addr_i] <= wr_rank_i;
    end
  end

  // Registered read port, one entry per cycle.
  always_ff @(posedge clk_i) begin
    rd_key_q  <= key_mem_q[rd_addr_i];
    rd_val_q  <= val_mem_q[rd_addr_i];
    rd_cnt_q  <= cnt_mem_q[rd_addr_i];
    rd_rank_q <= rank_mem_q[rd_addr_i];
  end

  assign rd_key_o  = rd_key_q;
  assign rd_val_o  = rd_val_q;
  assign rd_cnt_o  = rd_cnt_q;
  assign rd_rank_o = rd_rank_q;

endmodule

`default_nettype wire

// File: design/lfu_scan.sv
// Shared compare unit: key match, first free slot and eviction victim, one entry a cycle while enabled.
`timescale 1ns / 1ps
`default_nettype none

module lfu_scan import lfu_pkg::*; #(
  parameter int unsigned IdxW = 4
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              clr_i,
  input  wire logic              en_i,
  input  wire logic [IdxW-1:0]   idx_i,
  input  wire logic              ent_valid_i,
  input  wire logic [KeyW-1:0]   key_i,
  input  wire logic [KeyW-1:0]   rd_key_i,
  input  wire logic [ValW-1:0]   rd_val_i,
  input  wire logic [CountW-1:0] rd_cnt_i,
  input  wire logic [IdxW-1:0]   rd_rank_i,
  output lfu_scan_flags_t        flags_o,
  output logic      [IdxW-1:0]   found_idx_o,
  output logic      [ValW-1:0]   found_val_o,
  output logic      [CountW-1:0] found_cnt_o,
  output logic      [IdxW-1:0]   found_rank_o,
  output logic      [IdxW-1:0]   free_idx_o,
  output logic      [IdxW-1:0]   vic_idx_o,
  output logic      [KeyW-1:0]   vic_key_o,
  output logic      [IdxW-1:0]   vic_rank_o
);

  lfu_scan_flags_t   flags_q, flags_d;
  logic [IdxW-1:0]   found_idx_q, found_rank_q, free_idx_q, vic_idx_q, vic_rank_q;
  logic [ValW-1:0]   found_val_q;
  logic [CountW-1:0] found_cnt_q, vic_cnt_q;
  logic [KeyW-1:0]   vic_key_q;
  logic              match, is_free, better;

  // Compare the entry on the read port against the request and the current victim.
  assign match   = ent_valid_i && (rd_key_i == key_i) && !flags_q.found;
  assign is_free = !ent_valid_i && !flags_q.free;
  assign better  = ent_valid_i &&
                   (!flags_q.victim || (rd_cnt_i < vic_cnt_q) ||
                    ((rd_cnt_i == vic_cnt_q) && (rd_rank_i > vic_rank_q)));

  always_comb begin
    flags_d = flags_q;
    if (clr_i) begin
      flags_d = '0;
    end else if (en_i) begin
      if (match) begin
        flags_d.found = 1'b1;
      end
      if (is_free) begin
        flags_d.free = 1'b1;
      end
      if (better) begin
        flags_d.victim = 1'b1;
      end
    end
  end

  // Outcome flags are control state and are cleared at reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else begin
      flags_q <= flags_d;
    end
  end

  // Capture the details of whatever the flags point at.
  always_ff @(posedge clk_i) begin
    if (en_i && !clr_i) begin
      if (match) begin
        found_idx_q  <= idx_i;
        found_val_q  <= rd_val_i;
        found_cnt_q  <= rd_cnt_i;
        found_rank_q <= rd_rank_i;
      end
      if (is_free) begin
        free_idx_q <= idx_i;
      end
      if (better) begin
        vic_idx_q  <= idx_i;
        vic_key_q  <= rd_key_i;
        vic_cnt_q  <= rd_cnt_i;
        vic_rank_q <= rd_rank_i;
      end
    end
  end

  assign flags_o      = flags_q;
  assign found_idx_o  = found_idx_q;
  assign found_val_o  = found_val_q;
  assign found_cnt_o  = found_cnt_q;
  assign found_rank_o = found_rank_q;
  assign free_idx_o   = free_idx_q;
  assign vic_idx_o    = vic_idx_q;
  assign vic_key_o    = vic_key_q;
  assign vic_rank_o   = vic_rank_q;

endmodule

`default_nettype wire

// File: design/lfu_cache_controller.sv
// Top level of the LFU cache controller: request sequencer, valid bits and result register.
`timescale 1ns / 1ps
`default_nettype none

// Fully associative key/value cache with least-frequently-used replacement and a
// least-recently-used tie-break. Each request walks the entry memories one entry per
// cycle through a single compare unit, looking for the key, the first free slot and
// the eviction victim, and then decides. A request that changes the recency order (a
// hit, or an insert) then walks the rank memory once more to age the newer entries;
// the walks run one after the other over the single read port of the entry memories.
// The input stalls until the result of a request is loaded into an output register;
// it waits there, so the next request can be taken meanwhile. Valid bits are cleared
// by reset, so no clearing pass is needed. The capacity register is to be written
// only while the block is idle; the block itself does not enforce this. Values above
// ENTRIES act as ENTRIES and zero makes a put do nothing.
module lfu_cache_controller import lfu_pkg::*; #(
  parameter int unsigned ENTRIES = EntriesDef
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [CapW-1:0]   cfg_capacity_i,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic              opcode_i,
  input  wire logic signed [KeyW-1:0] key_i,
  input  wire logic signed [ValW-1:0] value_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic                   hit_o,
  output logic signed [ValW-1:0] read_value_o,
  output logic                   evicted_o,
  output logic signed [KeyW-1:0] evicted_key_o
);

  localparam int unsigned IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned OccW = $clog2(ENTRIES + 1);
  localparam int unsigned CmpW = (OccW > CapW) ? OccW : CapW;

  // Sequencer states.
  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StScan   = 3'd1;
  localparam logic [2:0] StDecide = 3'd2;
  localparam logic [2:0] StSweep  = 3'd3;
  localparam logic [2:0] StDone   = 3'd4;

  logic [2:0]        state_q, state_d;
  logic [CapW-1:0]   capacity_q;
  logic [ENTRIES-1:0] valid_q, valid_d;
  logic [OccW-1:0]   occ_q, occ_d;
  logic [OccW-1:0]   cnt_q, cnt_d;
  logic              pend_q, pend_d;
  logic [IdxW-1:0]   pend_idx_q, pend_idx_d;
  logic              op_q;
  logic [KeyW-1:0]   key_q;
  logic [ValW-1:0]   val_q;
  logic [IdxW-1:0]   slot_q, slot_d;
  logic [IdxW-1:0]   rank_lim_q, rank_lim_d;
  logic              res_hit_q, res_hit_d, res_ev_q, res_ev_d;
  logic [ValW-1:0]   res_rv_q, res_rv_d;
  logic [KeyW-1:0]   res_evkey_q, res_evkey_d;
  logic              out_v_q, out_v_d;
  logic              out_hit_q, out_ev_q;
  logic [ValW-1:0]   out_rv_q;
  logic [KeyW-1:0]   out_evkey_q;

  logic              accept, walk_done, out_load, sweep_cond;
  logic [CmpW-1:0]   cap_eff;
  logic              cap_zero, full;
  logic              do_bump, do_new, do_alloc;
  logic [CountW-1:0] bump_cnt;

  logic [IdxW-1:0]   rd_addr, wr_addr;
  lfu_wr_en_t        wr_en;
  logic [CountW-1:0] wr_cnt;
  logic [IdxW-1:0]   wr_rank;
  logic [KeyW-1:0]   rd_key;
  logic [ValW-1:0]   rd_val;
  logic [CountW-1:0] rd_cnt;
  logic [IdxW-1:0]   rd_rank;

  lfu_scan_flags_t   sc_flags;
  logic [IdxW-1:0]   sc_found_idx, sc_found_rank, sc_free_idx, sc_vic_idx, sc_vic_rank;
  logic [ValW-1:0]   sc_found_val;
  logic [CountW-1:0] sc_found_cnt;
  logic [KeyW-1:0]   sc_vic_key;

  // Handshakes.
  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != StIdle);
  assign accept      = in_valid_i && (state_q == StIdle);
  assign walk_done   = (cnt_q == OccW'(ENTRIES)) && !pend_q;
  assign out_load    = (state_q == StDone) && (!out_v_q || !out_stall_i);

  // Effective capacity, limited to the number of entries.
  assign cap_eff  = (CmpW'(capacity_q) > CmpW'(ENTRIES)) ? CmpW'(ENTRIES) : CmpW'(capacity_q);
  assign cap_zero = (cap_eff == '0);
  assign full     = (CmpW'(occ_q) >= cap_eff);
  assign bump_cnt = (sc_found_cnt == CountMax) ? CountMax : sc_found_cnt + CountW'(1);

  // Decision on the scan outcome: bump a hit, place a new entry, or leave the store as it is.
  always_comb begin
    do_bump     = 1'b0;
    do_new      = 1'b0;
    do_alloc    = 1'b0;
    slot_d      = slot_q;
    rank_lim_d  = rank_lim_q;
    res_hit_d   = 1'b0;
    res_rv_d    = '0;
    res_ev_d    = 1'b0;
    res_evkey_d = '0;
    if (op_q == OpGet) begin
      if (sc_flags.found) begin
        do_bump   = 1'b1;
        res_hit_d = 1'b1;
        res_rv_d  = sc_found_val;
      end
    end else if (!cap_zero) begin
      if (sc_flags.found) begin
        do_bump   = 1'b1;
        res_hit_d = 1'b1;
      end else if (full) begin
        if (sc_flags.victim) begin
          do_new      = 1'b1;
          res_ev_d    = 1'b1;
          res_evkey_d = sc_vic_key;
          slot_d      = sc_vic_idx;
          rank_lim_d  = sc_vic_rank;
        end
      end else if (sc_flags.free) begin
        do_new     = 1'b1;
        do_alloc   = 1'b1;
        slot_d     = sc_free_idx;
        rank_lim_d = occ_q[IdxW-1:0];
      end
    end
    if (do_bump) begin
      slot_d     = sc_found_idx;
      rank_lim_d = sc_found_rank;
    end
  end

  // Rank aging: valid entries newer than the touched one move back by one.
  assign sweep_cond = pend_q && valid_q[pend_idx_q] && (pend_idx_q != slot_q) &&
                      (rd_rank < rank_lim_q);

  // Memory port selection.
  always_comb begin
    rd_addr = cnt_q[IdxW-1:0];
    wr_addr = slot_d;
    wr_en   = '0;
    wr_cnt  = bump_cnt;
    wr_rank = '0;
    case (state_q)
      StDecide: begin
        wr_en.key  = do_new;
        wr_en.val  = do_new || (do_bump && (op_q == OpPut));
        wr_en.cnt  = do_new || do_bump;
        wr_en.rank = do_new || do_bump;
        wr_cnt     = do_new ? CountInit : bump_cnt;
      end
      StSweep: begin
        wr_addr    = pend_idx_q;
        wr_en.rank = sweep_cond;
        wr_rank    = rd_rank + IdxW'(1);
      end
      default: begin
        wr_en = '0;
      end
    endcase
  end

  // Sequencer.
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    pend_d     = 1'b0;
    pend_idx_d = pend_idx_q;
    valid_d    = valid_q;
    occ_d      = occ_q;
    case (state_q)
      StIdle: begin
        if (accept) begin
          cnt_d   = '0;
          state_d = StScan;
        end
      end
      StScan, StSweep: begin
        if (cnt_q != OccW'(ENTRIES)) begin
          pend_d     = 1'b1;
          pend_idx_d = cnt_q[IdxW-1:0];
          cnt_d      = cnt_q + OccW'(1);
        end else if (walk_done) begin
          state_d = (state_q == StScan) ? StDecide : StDone;
        end
      end
      StDecide: begin
        cnt_d = '0;
        if (do_alloc) begin
          valid_d[slot_d] = 1'b1;
          occ_d           = occ_q + OccW'(1);
        end
        state_d = (do_new || do_bump) ? StSweep : StDone;
      end
      StDone: begin
        if (out_load) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Result register towards the output channel.
  always_comb begin
    out_v_d = out_v_q;
    if (out_load) begin
      out_v_d = 1'b1;
    end else if (out_v_q && !out_stall_i) begin
      out_v_d = 1'b0;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      capacity_q <= CapacityRst;
      valid_q    <= '0;
      occ_q      <= '0;
      cnt_q      <= '0;
      pend_q     <= 1'b0;
      out_v_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        capacity_q <= cfg_capacity_i;
      end
      valid_q <= valid_d;
      occ_q   <= occ_d;
      cnt_q   <= cnt_d;
      pend_q  <= pend_d;
      out_v_q <= out_v_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    pend_idx_q <= pend_idx_d;
    if (accept) begin
      op_q  <= opcode_i;
      key_q <= key_i;
      val_q <= value_i;
    end
    if (state_q == StDecide) begin
      slot_q      <= slot_d;
      rank_lim_q  <= rank_lim_d;
      res_hit_q   <= res_hit_d;
      res_rv_q    <= res_rv_d;
      res_ev_q    <= res_ev_d;
      res_evkey_q <= res_evkey_d;
    end
    if (out_load) begin
      out_hit_q   <= res_hit_q;
      out_rv_q    <= res_rv_q;
      out_ev_q    <= res_ev_q;
      out_evkey_q <= res_evkey_q;
    end
  end

  lfu_store #(
    .ENTRIES (ENTRIES),
    .IdxW    (IdxW)
  ) u_store (
    .clk_i     (clk_i),
    .rd_addr_i (rd_addr),
    .rd_key_o  (rd_key),
    .rd_val_o  (rd_val),
    .rd_cnt_o  (rd_cnt),
    .rd_rank_o (rd_rank),
    .wr_addr_i (wr_addr),
    .wr_en_i   (wr_en),
    .wr_key_i  (key_q),
    .wr_val_i  (val_q),
    .wr_cnt_i  (wr_cnt),
    .wr_rank_i (wr_rank)
  );

  lfu_scan #(
    .IdxW (IdxW)
  ) u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .clr_i        (accept),
    .en_i         (pend_q && (state_q == StScan)),
    .idx_i        (pend_idx_q),
    .ent_valid_i  (valid_q[pend_idx_q]),
    .key_i        (key_q),
    .rd_key_i     (rd_key),
    .rd_val_i     (rd_val),
    .rd_cnt_i     (rd_cnt),
    .rd_rank_i    (rd_rank),
    .flags_o      (sc_flags),
    .found_idx_o  (sc_found_idx),
    .found_val_o  (sc_found_val),
    .found_cnt_o  (sc_found_cnt),
    .found_rank_o (sc_found_rank),
    .free_idx_o   (sc_free_idx),
    .vic_idx_o    (sc_vic_idx),
    .vic_key_o    (sc_vic_key),
    .vic_rank_o   (sc_vic_rank)
  );

  assign out_valid_o   = out_v_q;
  assign hit_o         = out_hit_q;
  assign read_value_o  = out_rv_q;
  assign evicted_o     = out_ev_q;
  assign evicted_key_o = out_evkey_q;

endmodule

`default_nettype wire

// File: design/lfu_checker.sv
// Port-level checks of the LFU cache controller, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "lfu_cache_controller_macros.svh"

module lfu_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic        hit_o,
  input wire logic [31:0] read_value_o,
  input wire logic        evicted_o,
  input wire logic [31:0] evicted_key_o
);

  // A taken request keeps the block busy in the following cycle.
  `LFU_ASSERT_NEXT(a_busy_after_req, in_valid_i && !in_stall_o, in_stall_o)

  // Only a miss can evict, so a result never shows both.
  `LFU_ASSERT_IMPL(a_hit_no_evict, out_valid_o, !(hit_o && evicted_o))

  // A miss returns a zero read value.
  `LFU_ASSERT_IMPL(a_miss_zero_value, out_valid_o && !hit_o, read_value_o == 32'd0)

  // Without an eviction the evicted key reads zero.
  `LFU_ASSERT_IMPL(a_no_evict_zero_key, out_valid_o && !evicted_o, evicted_key_o == 32'd0)

  // A held result keeps its value.
  `LFU_ASSERT_NEXT(a_held_result, out_valid_o && out_stall_i, $stable(read_value_o))

endmodule

bind lfu_cache_controller lfu_checker u_lfu_checker (.*);

`default_nettype wire
